// ===== rtl/arp_pkg.sv =====
package arp_pkg;

    localparam int ENTRIES = 64;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = IDX_W + 1;

    localparam int IP_W    = 32;
    localparam int MAC_W   = 48;
    localparam int TIME_W  = 32;
    localparam int AGE_W   = 16;
    localparam int SLOT_W  = 6;
    localparam int EXP_W   = 7;

    localparam logic [AGE_W-1:0] AGE_LIMIT_RST = AGE_W'(15);

    typedef enum logic [1:0] {
        FUNC_LOOKUP = 2'd0,
        FUNC_INSERT = 2'd1,
        FUNC_TICK   = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [IP_W-1:0]   ip;
        logic [MAC_W-1:0]  mac;
        logic [TIME_W-1:0] added;
    } t_entry;

endpackage

// ===== rtl/arp_cache_table_top.sv =====
// one item at a time: a new item is accepted only in idle, after the last result strobe;
// lookup and tick scan every entry, insert stops at the first free slot or when full,
// with a scan of one entry per cycle through the single-port entry memory; an undefined
// func goes straight to the result
// results are shown for one cycle on o_strobe; the receiver cannot stall
// reset clears all valid bits, the seconds counter and restores age_limit to 15
module arp_cache_table_top
    import arp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic [1:0]         i_func,
    input  logic [IP_W-1:0]    i_ip_addr,
    input  logic [MAC_W-1:0]   i_mac_in,
    input  logic               i_cfg_we,
    input  logic [AGE_W-1:0]   i_cfg_data,
    output logic               o_strobe,
    output logic               o_found,
    output logic [MAC_W-1:0]   o_mac_out,
    output logic               o_stored,
    output logic [SLOT_W-1:0]  o_slot,
    output logic [EXP_W-1:0]   o_expired_count
);

    t_entry               mem [ENTRIES];

    t_state               r_state, n_state;
    t_func                r_func;
    logic [IP_W-1:0]      r_ip;
    logic [MAC_W-1:0]     r_mac;
    logic [CNT_W-1:0]     r_addr;
    logic                 r_p_vld;
    logic [IDX_W-1:0]     r_p_idx;
    t_entry               r_rd_data;
    logic [ENTRIES-1:0]   r_valid;
    logic [TIME_W-1:0]    r_now;
    logic [AGE_W-1:0]     r_age_limit;

    logic                 r_found;
    logic [MAC_W-1:0]     r_mac_out;
    logic                 r_stored;
    logic [IDX_W-1:0]     r_slot;
    logic [EXP_W-1:0]     r_expired;

    logic                 accept;
    logic                 scan_end;
    logic [IDX_W-1:0]     addr_idx;
    logic                 slot_free;
    logic                 mem_re;
    logic                 mem_we;
    logic [TIME_W-1:0]    age;
    logic                 hit;
    logic                 stale;

    assign accept    = i_start && (r_state == ST_IDLE);
    assign scan_end  = (r_addr == CNT_W'(ENTRIES));
    assign addr_idx  = r_addr[IDX_W-1:0];
    assign slot_free = !r_valid[addr_idx];
    assign age       = r_now - r_rd_data.added;
    assign hit       = r_p_vld && r_valid[r_p_idx] && (r_rd_data.ip == r_ip);
    assign stale     = r_p_vld && r_valid[r_p_idx] && (age > TIME_W'(r_age_limit));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    if (i_func inside {FUNC_LOOKUP, FUNC_INSERT, FUNC_TICK}) begin
                        n_state = ST_SCAN;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_SCAN: begin
                if (r_func == FUNC_INSERT) begin
                    if (scan_end || slot_free) begin
                        n_state = ST_DONE;
                    end
                end else if (scan_end && !r_p_vld) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb begin
        o_busy   = 1'b1;
        o_strobe = 1'b0;
        mem_re   = 1'b0;
        mem_we   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_busy = 1'b0;
            end
            ST_SCAN: begin
                mem_re = (r_func != FUNC_INSERT) && !scan_end;
                mem_we = (r_func == FUNC_INSERT) && !scan_end && slot_free;
            end
            ST_DONE: begin
                o_strobe = 1'b1;
            end
            default: begin
                o_busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // entry memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[addr_idx] <= '{ip: r_ip, mac: r_mac, added: r_now};
        end
        if (mem_re) begin
            r_rd_data <= mem[addr_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_age_limit <= AGE_LIMIT_RST;
        end else if (i_cfg_we) begin
            r_age_limit <= i_cfg_data;
        end
    end

    // scan control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_now   <= '0;
            r_addr  <= '0;
            r_p_vld <= 1'b0;
        end else begin
            r_p_vld <= mem_re;
            if (accept) begin
                r_addr <= '0;
                if (i_func == FUNC_TICK) begin
                    r_now <= r_now + TIME_W'(1);
                end
            end else if (mem_re) begin
                r_addr <= r_addr + CNT_W'(1);
            end else if (r_state == ST_SCAN && r_func == FUNC_INSERT && !scan_end) begin
                r_addr <= r_addr + CNT_W'(1);
            end
            if (mem_we) begin
                r_valid[addr_idx] <= 1'b1;
            end
            if (r_func == FUNC_TICK && stale) begin
                r_valid[r_p_idx] <= 1'b0;
            end
        end
    end

    // item and result registers
    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_p_idx <= addr_idx;
        end
        if (accept) begin
            r_func    <= t_func'(i_func);
            r_ip      <= i_ip_addr;
            r_mac     <= i_mac_in;
            r_found   <= 1'b0;
            r_mac_out <= '0;
            r_stored  <= 1'b0;
            r_slot    <= '0;
            r_expired <= '0;
        end else if (r_state == ST_SCAN) begin
            if (r_func == FUNC_LOOKUP && hit) begin
                r_found   <= 1'b1;
                r_mac_out <= r_rd_data.mac;
                r_slot    <= r_p_idx;
            end
            if (mem_we) begin
                r_stored <= 1'b1;
                r_slot   <= addr_idx;
            end
            if (r_func == FUNC_TICK && stale && r_expired != {EXP_W{1'b1}}) begin
                r_expired <= r_expired + EXP_W'(1);
            end
        end
    end

    assign o_found         = r_found;
    assign o_mac_out       = r_mac_out;
    assign o_stored        = r_stored;
    assign o_slot          = SLOT_W'(r_slot);
    assign o_expired_count = r_expired;

    a_strobe_ends_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_busy && !o_strobe)
        else $error("result strobe not followed by idle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("accepted item did not raise busy");

    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !(o_found && o_stored) && (o_expired_count == '0 ||
        (!o_found && !o_stored)))
        else $error("result mixes operations");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_found) |-> o_mac_out == '0)
        else $error("mac_out nonzero without a match");

    a_insert_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |=> $countones(r_valid) == $past($countones(r_valid)) + 1)
        else $error("insert did not add one valid entry");

endmodule

// ===== tb/testbench.sv =====
module testbench
    import arp_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] FUNC_UNDEF  = 2'd3;
    localparam int         ITEM_TARGET = 1165;
    localparam int         CALM_ITEMS  = 135;
    localparam int         QUIET_LIMIT = 4000;

    typedef enum logic [1:0] {
        ACT_ITEM,
        ACT_CFG,
        ACT_DRAIN
    } t_act;

    typedef struct packed {
        t_act              act;
        logic [1:0]        func;
        logic [IP_W-1:0]   ip;
        logic [MAC_W-1:0]  mac;
        logic [AGE_W-1:0]  cfg;
        logic [4:0]        gap;
    } t_work;

    typedef struct packed {
        logic              found;
        logic [MAC_W-1:0]  mac;
        logic              stored;
        logic [SLOT_W-1:0] slot;
        logic [EXP_W-1:0]  expired;
    } t_reply;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_start = 1'b0;
    logic               o_busy;
    logic [1:0]         i_func = FUNC_LOOKUP;
    logic [IP_W-1:0]    i_ip_addr = '0;
    logic [MAC_W-1:0]   i_mac_in = '0;
    logic               i_cfg_we = 1'b0;
    logic [AGE_W-1:0]   i_cfg_data = '0;
    logic               o_strobe;
    logic               o_found;
    logic [MAC_W-1:0]   o_mac_out;
    logic               o_stored;
    logic [SLOT_W-1:0]  o_slot;
    logic [EXP_W-1:0]   o_expired_count;

    // table model
    logic               tbl_valid [ENTRIES];
    logic [IP_W-1:0]    tbl_ip    [ENTRIES];
    logic [MAC_W-1:0]   tbl_mac   [ENTRIES];
    logic [TIME_W-1:0]  tbl_added [ENTRIES];
    logic [TIME_W-1:0]  seconds_now = '0;
    logic [AGE_W-1:0]   age_limit_now = AGE_LIMIT_RST;

    t_work              work_q [$];
    t_reply             replies_due [$];
    logic [IP_W-1:0]    known_ips [$];
    int                 queued_items = 0;
    int                 gap_left = 0;
    int                 quiet_cycles = 0;
    int                 errors = 0;
    bit                 item_taken = 1'b0;
    bit                 stim_done = 1'b0;

    arp_cache_table_top DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .o_busy          (o_busy),
        .i_func          (i_func),
        .i_ip_addr       (i_ip_addr),
        .i_mac_in        (i_mac_in),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .o_strobe        (o_strobe),
        .o_found         (o_found),
        .o_mac_out       (o_mac_out),
        .o_stored        (o_stored),
        .o_slot          (o_slot),
        .o_expired_count (o_expired_count)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    function automatic t_reply resolve_op(input logic [1:0] func, input logic [IP_W-1:0] ip,
                                          input logic [MAC_W-1:0] mac);
        t_reply r;
        int     free_idx;
        r = '0;
        free_idx = -1;
        case (func)
            FUNC_LOOKUP: begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (tbl_valid[i] && tbl_ip[i] == ip) begin
                        r.found = 1'b1;
                        r.mac   = tbl_mac[i];
                        r.slot  = SLOT_W'(i);
                    end
                end
            end
            FUNC_INSERT: begin
                for (int i = ENTRIES - 1; i >= 0; i--) begin
                    if (!tbl_valid[i])
                        free_idx = i;
                end
                if (free_idx >= 0) begin
                    tbl_valid[free_idx] = 1'b1;
                    tbl_ip[free_idx]    = ip;
                    tbl_mac[free_idx]   = mac;
                    tbl_added[free_idx] = seconds_now;
                    r.stored = 1'b1;
                    r.slot   = SLOT_W'(free_idx);
                end
            end
            FUNC_TICK: begin
                seconds_now = seconds_now + 1'b1;
                for (int i = 0; i < ENTRIES; i++) begin
                    if (tbl_valid[i] && (seconds_now - tbl_added[i]) > TIME_W'(age_limit_now))
                    begin
                        tbl_valid[i] = 1'b0;
                        if (r.expired != 7'd127)
                            r.expired = r.expired + 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [MAC_W-1:0] want,
                                 input logic [MAC_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endtask

    task automatic queue_item(input logic [1:0] func, input logic [IP_W-1:0] ip,
                              input logic [MAC_W-1:0] mac);
        t_work w;
        w = '0;
        w.act  = ACT_ITEM;
        w.func = func;
        w.ip   = ip;
        w.mac  = mac;
        if (queued_items < ITEM_TARGET - CALM_ITEMS && $urandom_range(99) < 30)
            w.gap = 5'($urandom_range(18, 1));
        work_q.push_back(w);
        queued_items++;
    endtask

    task automatic queue_ctrl(input t_act act, input logic [AGE_W-1:0] value);
        t_work w;
        w = '0;
        w.act = act;
        w.cfg = value;
        work_q.push_back(w);
    endtask

    task automatic queue_random(input int n, input int ins_pct, input int tick_pct);
        int              roll;
        logic [IP_W-1:0] ip;
        logic [MAC_W-1:0] mac;
        for (int k = 0; k < n; k++) begin
            roll = $urandom_range(99);
            mac  = MAC_W'({$urandom, $urandom});
            if (roll < 3) begin
                queue_item(FUNC_UNDEF, $urandom, mac);
            end else if (roll < 3 + ins_pct) begin
                if (known_ips.size() > 0 && $urandom_range(99) < 30) begin
                    ip = known_ips[$urandom_range(known_ips.size() - 1)];
                end else begin
                    case ($urandom_range(19))
                        0:       ip = '0;
                        1:       ip = '1;
                        default: ip = $urandom;
                    endcase
                    if (known_ips.size() >= 40)
                        known_ips[$urandom_range(39)] = ip;
                    else
                        known_ips.push_back(ip);
                end
                queue_item(FUNC_INSERT, ip, mac);
            end else if (roll < 3 + ins_pct + tick_pct) begin
                queue_item(FUNC_TICK, $urandom, mac);
            end else begin
                if (known_ips.size() > 0 && $urandom_range(99) < 80)
                    ip = known_ips[$urandom_range(known_ips.size() - 1)];
                else
                    ip = $urandom;
                queue_item(FUNC_LOOKUP, ip, mac);
            end
            if (queued_items < ITEM_TARGET - CALM_ITEMS && $urandom_range(199) == 0)
                queue_ctrl(ACT_DRAIN, '0);
        end
    endtask

    always @(negedge i_clk) begin : drive_items
        logic  nx_start;
        logic  nx_we;
        t_work w;
        nx_start = i_start;
        nx_we    = 1'b0;
        if (i_rst_n) begin
            if (i_start && item_taken)
                nx_start = 1'b0;
            if (!nx_start) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (work_q.size() > 0) begin
                    w = work_q[0];
                    case (w.act)
                        ACT_ITEM: begin
                            nx_start  = 1'b1;
                            i_func    <= w.func;
                            i_ip_addr <= w.ip;
                            i_mac_in  <= w.mac;
                            gap_left  = w.gap;
                            void'(work_q.pop_front());
                        end
                        ACT_CFG: begin
                            if (replies_due.size() == 0) begin
                                nx_we      = 1'b1;
                                i_cfg_data <= w.cfg;
                                void'(work_q.pop_front());
                            end
                        end
                        default: begin
                            if (replies_due.size() == 0)
                                void'(work_q.pop_front());
                        end
                    endcase
                end else begin
                    stim_done = 1'b1;
                end
            end
        end
        i_start  <= nx_start;
        i_cfg_we <= nx_we;
    end

    always @(posedge i_clk) begin : watch_results
        t_reply want;
        logic   took;
        logic   progress;
        took = i_rst_n && i_start && !o_busy;
        progress = took;
        item_taken <= took;
        if (i_rst_n && i_cfg_we)
            age_limit_now = i_cfg_data;
        if (i_rst_n && o_strobe) begin
            if (replies_due.size() == 0) begin
                $error("result with no item pending");
                errors++;
            end else begin
                want = replies_due.pop_front();
                progress = 1'b1;
                compare_field("found", MAC_W'(want.found), MAC_W'(o_found));
                compare_field("mac_out", want.mac, o_mac_out);
                compare_field("stored", MAC_W'(want.stored), MAC_W'(o_stored));
                compare_field("slot", MAC_W'(want.slot), MAC_W'(o_slot));
                compare_field("expired_count", MAC_W'(want.expired), MAC_W'(o_expired_count));
            end
        end
        if (took)
            replies_due.push_back(resolve_op(i_func, i_ip_addr, i_mac_in));
        if (progress)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < ENTRIES; i++)
            tbl_valid[i] = 1'b0;

        queue_item(FUNC_LOOKUP, '0, '0);
        queue_item(FUNC_INSERT, '0, '0);
        queue_item(FUNC_INSERT, '1, '1);
        queue_item(FUNC_INSERT, 32'h0A00_0001, 48'h0123_4567_89AB);
        // duplicate address, highest slot must win
        queue_item(FUNC_INSERT, 32'h0A00_0001, 48'hA5A5_5A5A_C3C3);
        queue_item(FUNC_LOOKUP, 32'h0A00_0001, '0);
        queue_item(FUNC_LOOKUP, '1, '1);
        queue_item(FUNC_LOOKUP, '0, '1);
        queue_item(FUNC_LOOKUP, 32'h0A00_0002, '0);
        queue_item(FUNC_UNDEF, '1, '1);
        queue_item(FUNC_TICK, '0, '0);
        queue_item(FUNC_LOOKUP, 32'h0A00_0001, '0);
        queue_ctrl(ACT_CFG, 16'd0);
        queue_item(FUNC_TICK, '1, '1);
        queue_item(FUNC_LOOKUP, '0, '0);

        queue_ctrl(ACT_CFG, 16'hFFFF);
        queue_random(200, 50, 10);
        queue_ctrl(ACT_CFG, 16'd2);
        queue_random(140, 35, 25);
        queue_ctrl(ACT_CFG, 16'd0);
        queue_random(120, 40, 20);
        queue_ctrl(ACT_CFG, 16'd1);
        queue_random(120, 40, 20);
        queue_ctrl(ACT_CFG, 16'd300);
        queue_random(150, 45, 15);
        queue_ctrl(ACT_CFG, 16'd7);
        queue_random(140, 35, 25);
        queue_ctrl(ACT_CFG, AGE_LIMIT_RST);
        queue_random(140, 35, 20);
        queue_ctrl(ACT_CFG, 16'd40000);
        queue_random(140, 40, 15);

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        do
            @(posedge i_clk);
        while (!(stim_done && replies_due.size() == 0));
        repeat (ENTRIES + 8) @(posedge i_clk);

        if (errors == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
